### design/scs_pkg.sv
// Shared types, constants and state encoding for the sparse cosine similarity block.
`default_nettype none
package scs_pkg;
    localparam int MaxEntries = 256;
    localparam int IdBits     = 20;
    localparam int WtBits     = 16;
    localparam int AddrBits   = $clog2(MaxEntries);
    localparam int CntBits    = AddrBits + 1;
    localparam int AccBits    = 64;
    localparam int RootBits   = 32;

    localparam logic [1:0] ReqFirst  = 2'd0;
    localparam logic [1:0] ReqSecond = 2'd1;
    localparam logic [1:0] ReqFinish = 2'd2;

    localparam logic [1:0] StatOk       = 2'd0;
    localparam logic [1:0] StatZeroNorm = 2'd1;
    localparam logic [1:0] StatDropped  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [19:0] term_index;
        logic [15:0] weight;
    } t_in;

    typedef struct packed {
        logic [15:0] similarity;
        logic [1:0]  status;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_MAC, S_SQA, S_SQB, S_MUL, S_DIV, S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr;        // clear accumulators and indices
        logic rd;         // issue memory reads at current indices
        logic mac;        // merge step on registered read data
        logic sqrt_a;     // run isqrt on norm A
        logic sqrt_b;     // run isqrt on norm B
        logic mul;        // form denominator
        logic div;        // run divider
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_done;
        logic unit_done;
    } t_sts;
endpackage
`default_nettype wire

### design/scs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module scs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]              o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### design/scs_ctrl.sv
// Controller state machine sequencing the merge walk, roots and divide.
`default_nettype none
module scs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_out_ready,
    input  wire scs_pkg::t_sts i_sts,
    output scs_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_out_valid
);
    import scs_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_RD;
            S_RD:   n_state = i_sts.walk_done ? S_SQA : S_WAIT;
            S_WAIT: n_state = S_MAC;
            S_MAC:  n_state = S_RD;
            S_SQA:  if (i_sts.unit_done) n_state = S_SQB;
            S_SQB:  if (i_sts.unit_done) n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (i_sts.unit_done) n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_busy      = (r_state != S_IDLE);
        o_out_valid = (r_state == S_OUT);
        case (r_state)
            S_IDLE: o_cmd.clr    = i_start;
            S_RD:   o_cmd.rd     = 1'b1;
            S_MAC:  o_cmd.mac    = 1'b1;
            S_SQA:  o_cmd.sqrt_a = 1'b1;
            S_SQB:  o_cmd.sqrt_b = 1'b1;
            S_MUL:  o_cmd.mul    = 1'b1;
            S_DIV:  o_cmd.div    = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### design/scs_dp.sv
// Datapath: entry stores, merge-join accumulators, isqrt and Q1.15 divider.
`default_nettype none
module scs_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire scs_pkg::t_in  i_item,
    input  wire logic          i_done,
    input  wire scs_pkg::t_cmd i_cmd,
    output scs_pkg::t_sts      o_sts,
    output scs_pkg::t_out      o_res
);
    import scs_pkg::*;

    logic [CntBits-1:0]  r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic                r_ovf, n_ovf;
    logic [CntBits-1:0]  r_ia, r_ib;
    logic [AccBits-1:0]  r_dot, r_na, r_nb;
    logic                r_va, r_vb;
    logic [IdBits-1:0]   id_a, id_b;
    logic [WtBits-1:0]   wt_a, wt_b;
    logic                we_a, we_b;

    assign we_a = i_load && (i_item.req_type == ReqFirst)
                  && (r_cnt_a < CntBits'(MaxEntries));
    assign we_b = i_load && (i_item.req_type == ReqSecond)
                  && (r_cnt_b < CntBits'(MaxEntries));

    scs_ram #(.Width(IdBits), .Depth(MaxEntries)) u_id_a (
        .i_clk, .i_we(we_a), .i_waddr(r_cnt_a[AddrBits-1:0]), .i_wdata(i_item.term_index),
        .i_raddr(r_ia[AddrBits-1:0]), .o_rdata(id_a));
    scs_ram #(.Width(WtBits), .Depth(MaxEntries)) u_wt_a (
        .i_clk, .i_we(we_a), .i_waddr(r_cnt_a[AddrBits-1:0]), .i_wdata(i_item.weight),
        .i_raddr(r_ia[AddrBits-1:0]), .o_rdata(wt_a));
    scs_ram #(.Width(IdBits), .Depth(MaxEntries)) u_id_b (
        .i_clk, .i_we(we_b), .i_waddr(r_cnt_b[AddrBits-1:0]), .i_wdata(i_item.term_index),
        .i_raddr(r_ib[AddrBits-1:0]), .o_rdata(id_b));
    scs_ram #(.Width(WtBits), .Depth(MaxEntries)) u_wt_b (
        .i_clk, .i_we(we_b), .i_waddr(r_cnt_b[AddrBits-1:0]), .i_wdata(i_item.weight),
        .i_raddr(r_ib[AddrBits-1:0]), .o_rdata(wt_b));

    always_comb begin
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_ovf   = r_ovf;
        if (i_load) begin
            if (i_item.req_type == ReqFirst) begin
                if (we_a) n_cnt_a = r_cnt_a + 1'b1;
                else      n_ovf   = 1'b1;
            end else if (i_item.req_type == ReqSecond) begin
                if (we_b) n_cnt_b = r_cnt_b + 1'b1;
                else      n_ovf   = 1'b1;
            end
        end
        if (i_done) begin
            n_cnt_a = '0;
            n_cnt_b = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_ovf   <= n_ovf;
        end
    end

    assign o_sts.walk_done = (r_ia >= r_cnt_a) && (r_ib >= r_cnt_b);

    // merge step: products registered before accumulation
    logic [2*WtBits-1:0] r_paa, r_pbb, r_pab;
    logic                r_take_a, r_take_b, r_both;
    logic                r_acc_go;

    function automatic logic [AccBits-1:0] sat_add(input logic [AccBits-1:0] a,
                                                   input logic [AccBits-1:0] b);
        logic [AccBits:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AccBits] ? '1 : s[AccBits-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_va <= r_ia < r_cnt_a;
            r_vb <= r_ib < r_cnt_b;
        end
        r_acc_go <= i_cmd.mac;
        if (i_cmd.clr) begin
            r_ia <= '0; r_ib <= '0;
            r_dot <= '0; r_na <= '0; r_nb <= '0;
        end else if (i_cmd.mac) begin
            r_paa <= wt_a * wt_a;
            r_pbb <= wt_b * wt_b;
            r_pab <= wt_a * wt_b;
            r_both   <= r_va && r_vb && (id_a == id_b);
            r_take_a <= r_va && (!r_vb || id_a <= id_b);
            r_take_b <= r_vb && (!r_va || id_b <= id_a);
            if (r_va && r_vb && id_a == id_b) begin
                r_ia <= r_ia + 1'b1; r_ib <= r_ib + 1'b1;
            end else if (!r_vb || (r_va && id_a < id_b)) begin
                r_ia <= r_ia + 1'b1;
            end else begin
                r_ib <= r_ib + 1'b1;
            end
        end
        if (r_acc_go) begin
            if (r_take_a) r_na <= sat_add(r_na, AccBits'(r_paa));
            if (r_take_b) r_nb <= sat_add(r_nb, AccBits'(r_pbb));
            if (r_both)   r_dot <= sat_add(r_dot, AccBits'(r_pab));
        end
    end

    // shared isqrt: one result bit per cycle (restoring, digit-by-digit)
    logic [AccBits-1:0]  r_rem, r_val;
    logic [RootBits-1:0] r_root, r_ra, r_rb;
    logic [5:0]          r_step;
    logic                r_busy, r_fin;
    logic [RootBits+1:0] trial;
    logic [AccBits+1:0]  rem_sh;
    logic                sq_go;

    assign sq_go = i_cmd.sqrt_a || i_cmd.sqrt_b;
    assign rem_sh = {r_rem, r_val[AccBits-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    // divider
    logic [AccBits-1:0] r_den;
    logic [AccBits-1:0] r_drem;
    logic [15:0]        r_q;
    logic [4:0]         r_dstep;
    logic               r_dbusy, r_dfin, r_sat;
    logic [AccBits:0]   dsh;

    assign dsh = {r_drem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_fin <= 1'b0; r_dbusy <= 1'b0; r_dfin <= 1'b0;
        end else begin
            r_fin  <= 1'b0;
            r_dfin <= 1'b0;
            if (sq_go && !r_busy && !r_fin) begin
                r_busy <= 1'b1;
                r_val  <= i_cmd.sqrt_a ? r_na : r_nb;
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end else if (r_busy) begin
                if (rem_sh >= (AccBits+2)'(trial)) begin
                    r_rem  <= AccBits'(rem_sh - (AccBits+2)'(trial));
                    r_root <= {r_root[RootBits-2:0], 1'b1};
                end else begin
                    r_rem  <= AccBits'(rem_sh);
                    r_root <= {r_root[RootBits-2:0], 1'b0};
                end
                r_val  <= {r_val[AccBits-3:0], 2'b00};
                r_step <= r_step + 1'b1;
                if (r_step == 6'(RootBits-1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (i_cmd.div && !r_dbusy && !r_dfin) begin
                r_dbusy <= 1'b1;
                r_sat   <= (r_dot >= r_den);
                r_drem  <= r_dot;
                r_q     <= '0;
                r_dstep <= '0;
            end else if (r_dbusy) begin
                // remainder stays below den, so the shifted value fits in 65 bits
                if (dsh >= {1'b0, r_den}) begin
                    r_drem <= AccBits'(dsh - {1'b0, r_den});
                    r_q    <= {r_q[14:0], 1'b1};
                end else begin
                    r_drem <= AccBits'(dsh);
                    r_q    <= {r_q[14:0], 1'b0};
                end
                r_dstep <= r_dstep + 1'b1;
                if (r_dstep == 5'd14) begin
                    r_dbusy <= 1'b0;
                    r_dfin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fin && i_cmd.sqrt_a) r_ra <= r_root;
        if (r_fin && i_cmd.sqrt_b) r_rb <= r_root;
        if (i_cmd.mul) r_den <= r_ra * r_rb;
    end

    assign o_sts.unit_done = r_fin || r_dfin;

    always_comb begin
        if (r_na == '0 || r_nb == '0) begin
            o_res.similarity = '0;
            o_res.status     = StatZeroNorm;
        end else begin
            o_res.similarity = r_sat ? 16'd32768 : r_q;
            o_res.status     = StatOk;
        end
        if (r_ovf) o_res.status = StatDropped;
    end
endmodule
`default_nettype wire

### design/sparse_cosine_similarity.sv
// Top level of the sparse cosine similarity block.
// Entry transfers (first/second vector) are taken one per cycle while idle, no result.
// A finish transfer runs s merge steps (max(na,nb) <= s <= na+nb), each a read,
// a wait and a merge state, then two integer square roots, a multiply and a
// bit-serial divide, then raises o_valid. Input stalls until the result is taken.
// Synchronous active-low reset empties both lists and clears the drop flag.
`default_nettype none
module sparse_cosine_similarity (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire scs_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output scs_pkg::t_out     o_data
);
    import scs_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy, acc, start, done;

    // Ready whenever the sequencer is idle; entries write memory directly.
    assign o_ready = !busy;
    assign acc     = i_valid && o_ready;
    assign start   = acc && (i_data.req_type == ReqFinish);
    // Lists are emptied as the result transfers.
    assign done    = o_valid && i_ready;

    scs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_out_ready(i_ready),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy), .o_out_valid(o_valid));

    scs_dp u_dp (
        .i_clk, .i_rst_n, .i_load(acc), .i_item(i_data), .i_done(done),
        .i_cmd(cmd), .o_sts(sts), .o_res(o_data));

    // Result never beyond 1.0.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.similarity <= 16'd32768)
        else $error("similarity above 1.0");
    // No input taken while a finish is in flight.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !o_ready)
        else $error("input accepted during compute");
    // Result valid holds until transferred.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped");
endmodule
`default_nettype wire

### verif/scs_checker.sv
// Checker for the sparse cosine similarity block: predicts results and compares them.
`timescale 1ns / 1ps
module scs_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_ready_in,
    input  wire scs_pkg::t_in  i_data,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_ready,
    input  wire scs_pkg::t_out i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import scs_pkg::*;

    logic [IdBits-1:0] vec_a_ids [MaxEntries];
    logic [WtBits-1:0] vec_a_wts [MaxEntries];
    logic [IdBits-1:0] vec_b_ids [MaxEntries];
    logic [WtBits-1:0] vec_b_wts [MaxEntries];
    int   count_a, count_b;
    bit   dropped;
    t_out sim_queue [$];

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root, bit_pos;
        root = 0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > v) bit_pos >>= 2;
        while (bit_pos != 0) begin
            if (v >= root + bit_pos) begin
                v -= root + bit_pos;
                root = (root >> 1) + bit_pos;
            end else begin
                root >>= 1;
            end
            bit_pos >>= 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] q15_ratio(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem;
        logic [15:0] q;
        bit carry;
        if (num >= den) return 16'd32768;
        rem = num;
        q = 0;
        for (int i = 0; i < 15; i++) begin
            carry = rem[63];
            rem <<= 1;
            q <<= 1;
            if (carry || rem >= den) begin
                rem -= den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_out cosine_of_lists();
        logic [63:0] dot, na, nb, wa, wb;
        int ia, ib;
        t_out r;
        dot = 0; na = 0; nb = 0; ia = 0; ib = 0;
        while (ia < count_a || ib < count_b) begin
            if (ia < count_a && ib < count_b && vec_a_ids[ia] == vec_b_ids[ib]) begin
                wa = vec_a_wts[ia];
                wb = vec_b_wts[ib];
                dot = add_sat(dot, wa * wb);
                na = add_sat(na, wa * wa);
                nb = add_sat(nb, wb * wb);
                ia++; ib++;
            end else if (ib >= count_b || (ia < count_a && vec_a_ids[ia] < vec_b_ids[ib])) begin
                wa = vec_a_wts[ia];
                na = add_sat(na, wa * wa);
                ia++;
            end else begin
                wb = vec_b_wts[ib];
                nb = add_sat(nb, wb * wb);
                ib++;
            end
        end
        if (na == 0 || nb == 0) begin
            r.similarity = 0;
            r.status = StatZeroNorm;
        end else begin
            r.similarity = q15_ratio(dot, floor_sqrt(na) * floor_sqrt(nb));
            r.status = StatOk;
        end
        if (dropped) r.status = StatDropped;
        return r;
    endfunction

    assign o_pending = sim_queue.size();

    always @(posedge i_clk) begin
        t_out want;
        int   errs;
        errs = 0;
        if (!i_rst_n) begin
            count_a <= 0;
            count_b <= 0;
            dropped <= 0;
            o_fail_count <= 0;
            sim_queue.delete();
        end else begin
            // result side first: a finish accepted this edge cannot have a result yet
            if (i_out_valid && i_out_ready) begin
                if (sim_queue.size() == 0) begin
                    $error("unexpected result sim=%0d status=%0d",
                           i_out_data.similarity, i_out_data.status);
                    errs++;
                end else begin
                    want = sim_queue.pop_front();
                    if (want.similarity !== i_out_data.similarity) begin
                        $error("similarity expected %0d actual %0d",
                               want.similarity, i_out_data.similarity);
                        errs++;
                    end
                    if (want.status !== i_out_data.status) begin
                        $error("status expected %0d actual %0d",
                               want.status, i_out_data.status);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            if (i_valid && i_ready_in) begin
                case (i_data.req_type)
                    ReqFirst: begin
                        if (count_a >= MaxEntries) begin
                            dropped <= 1;
                        end else begin
                            vec_a_ids[count_a] = i_data.term_index;
                            vec_a_wts[count_a] = i_data.weight;
                            count_a <= count_a + 1;
                        end
                    end
                    ReqSecond: begin
                        if (count_b >= MaxEntries) begin
                            dropped <= 1;
                        end else begin
                            vec_b_ids[count_b] = i_data.term_index;
                            vec_b_wts[count_b] = i_data.weight;
                            count_b <= count_b + 1;
                        end
                    end
                    ReqFinish: begin
                        sim_queue.insert(sim_queue.size(), cosine_of_lists());
                        count_a <= 0;
                        count_b <= 0;
                        dropped <= 0;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

### verif/tb_top.sv
// Testbench top: stimulus, reset and verdict for the sparse cosine similarity block.
`timescale 1ns / 1ps
module tb_top;
    import scs_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic i_clk, i_rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    t_in  in_data;
    t_out out_data;
    int   fail_count, pending;
    int   idle_cycles;
    bit   calm;       // no idling on either side
    bit   hold_out;   // long receiver hold-off

    sparse_cosine_similarity uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_data(in_data),
        .o_valid(out_valid), .i_ready(out_ready), .o_data(out_data)
    );

    scs_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .i_ready_in(in_ready), .i_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stalls, except during calm or hold-off
    initial begin
        out_ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_out) out_ready <= 0;
            else out_ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one transfer; random gap before offering unless calm
    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(logic [1:0] kind, logic [19:0] id, logic [15:0] wt);
        while (!calm && $urandom_range(99) < 8) begin
            in_valid <= 0;
            @(negedge i_clk);
        end
        in_valid <= 1;
        in_data <= '{req_type: kind, term_index: id, weight: wt};
        while (!in_ready) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // pair of vectors; first-vector ids ascend, second-vector ids may not; some shared
    task automatic send_vector_pair(int n_a, int n_b, int id_span);
        logic [19:0] id_a, id_b;
        id_a = $urandom_range(id_span);
        id_b = ($urandom_range(1)) ? id_a : $urandom_range(id_span);
        for (int i = 0; i < n_a || i < n_b; i++) begin
            if (i < n_a) send_item(ReqFirst, id_a, $urandom);
            if (i < n_b) send_item(ReqSecond, id_b, $urandom);
            id_a += 1 + $urandom_range(id_span);
            id_b += 1 + $urandom_range(id_span);
            if ($urandom_range(2) == 0) id_b = id_a;
        end
        send_item(ReqFinish, $urandom, $urandom);
    endtask

    initial begin
        int sent, kind;
        in_valid = 0;
        in_data = '0;
        calm = 0;
        hold_out = 0;
        i_rst_n = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: empty lists, extremes, identical, disjoint, unused type
        send_item(ReqFinish, 0, 0);
        send_item(ReqFirst, 20'hFFFFF, 16'hFFFF);
        send_item(ReqSecond, 20'hFFFFF, 16'hFFFF);
        send_item(ReqFinish, 0, 0);
        send_item(ReqFirst, 0, 16'h0100);
        send_item(ReqSecond, 1, 16'h0100);
        send_item(ReqFinish, 20'hFFFFF, 16'hFFFF);
        send_item(ReqFirst, 5, 16'h0000);
        send_item(ReqSecond, 5, 16'h1234);
        send_item(2'd3, 20'hFFFFF, 16'hFFFF);
        send_item(ReqFinish, 0, 0);
        send_item(ReqFirst, 9, 16'h00FF);     // out-of-order ids
        send_item(ReqFirst, 3, 16'h7F00);
        send_item(ReqSecond, 3, 16'h8000);
        send_item(ReqSecond, 9, 16'h00FF);
        send_item(ReqFinish, 0, 0);
        wait_drained();

        // overflow: fill first list past capacity, calm so it streams
        calm = 1;
        for (int i = 0; i < MaxEntries + 3; i++) send_item(ReqFirst, i, $urandom);
        for (int i = 0; i < MaxEntries; i++) send_item(ReqSecond, i * 2, $urandom);
        send_item(ReqFinish, 0, 0);
        calm = 0;
        wait_drained();

        // receiver hold-off while the sender keeps going
        fork
            begin
                hold_out = 1;
                repeat (1500) @(negedge i_clk);
                hold_out = 0;
            end
            for (int j = 0; j < 6; j++) send_vector_pair(3, 3, 4);
        join
        wait_drained();

        sent = 0;
        while (sent < 1400) begin
            calm = (sent > 600 && sent < 900);
            kind = $urandom_range(9);
            if (kind < 8) begin
                int na, nb;
                na = $urandom_range(6);
                nb = $urandom_range(6);
                send_vector_pair(na, nb, (kind < 4) ? 3 : 20'hFFFF);
                sent += na + nb + 1;
            end else begin
                send_item($urandom_range(3), $urandom, $urandom);
                sent++;
            end
        end
        calm = 0;
        send_item(ReqFinish, 0, 0);
        in_valid <= 0;

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
